>>> rtl/mecr_pkg.sv
// Shared types, codes and constants for the MIDI event to CV router.
package mecr_pkg;

  // Clock ticks per divided clock pulse, in the range 1 to 15.
  localparam logic [3:0] CLOCK_DIVIDE = 4'd12;

  // Pitch bend center and the controller number of the modulation wheel.
  localparam logic [13:0] BEND_CENTER  = 14'd8192;
  localparam logic [6:0]  MOD_WHEEL_CC = 7'd1;

  // Configuration port geometry.
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 15;

  localparam logic [CFG_INDEX_W-1:0] REG_LISTEN_CHANNEL = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FUNCTION_A     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FUNCTION_B     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_FULL_SCALE     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_BEND_SCALE     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SEMITONE_STEP  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_ZERO_NOTE      = 3'd6;

  typedef enum logic [2:0] {
    KIND_CLOCK    = 3'd0,
    KIND_START    = 3'd1,
    KIND_NOTE_ON  = 3'd2,
    KIND_NOTE_OFF = 3'd3,
    KIND_CONTROL  = 3'd4,
    KIND_PRESSURE = 3'd5,
    KIND_BEND     = 3'd6,
    KIND_OTHER    = 3'd7
  } kind_t;

  typedef enum logic [3:0] {
    ROLE_NOTE  = 4'd0,
    ROLE_TRIG  = 4'd1,
    ROLE_GATE  = 4'd2,
    ROLE_VEL   = 4'd3,
    ROLE_MOD   = 4'd4,
    ROLE_AFT   = 4'd5,
    ROLE_BEND  = 4'd6,
    ROLE_CLOCK = 4'd7,
    ROLE_START = 4'd8
  } role_t;

  typedef enum logic [2:0] {
    ACT_NONE     = 3'd0,
    ACT_LEVEL    = 3'd1,
    ACT_PULSE    = 3'd2,
    ACT_GATE_ON  = 3'd3,
    ACT_GATE_OFF = 3'd4
  } act_t;

  typedef struct packed {
    logic [2:0] event_kind;
    logic [3:0] event_channel;
    logic [6:0] first_data;
    logic [6:0] second_data;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         a_action;
    logic signed [15:0] a_level;
    logic [2:0]         b_action;
    logic signed [15:0] b_level;
    logic               logged;
  } out_item_t;

  typedef struct packed {
    logic [3:0]  listen_channel;
    logic [3:0]  function_a;
    logic [3:0]  function_b;
    logic [14:0] full_scale_level;
    logic [14:0] bend_scale_level;
    logic [9:0]  semitone_step;
    logic [6:0]  zero_note;
  } cfg_t;

  // Candidate levels for one event, one per kind of scaling.
  typedef struct packed {
    logic signed [15:0] note;
    logic signed [15:0] prop;
    logic signed [15:0] bend;
  } levels_t;

endpackage

>>> rtl/mecr_cfg_regs.sv
// Configuration register file of the MIDI event to CV router.
module mecr_cfg_regs
  import mecr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output cfg_t                   cfg,
  output logic                   phase_clear
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_LISTEN_CHANNEL: cfg_nxt.listen_channel   = cfg_wdata[3:0];
        REG_FUNCTION_A:     cfg_nxt.function_a       = cfg_wdata[3:0];
        REG_FUNCTION_B:     cfg_nxt.function_b       = cfg_wdata[3:0];
        REG_FULL_SCALE:     cfg_nxt.full_scale_level = cfg_wdata[14:0];
        REG_BEND_SCALE:     cfg_nxt.bend_scale_level = cfg_wdata[14:0];
        REG_SEMITONE_STEP:  cfg_nxt.semitone_step    = cfg_wdata[9:0];
        REG_ZERO_NOTE:      cfg_nxt.zero_note        = cfg_wdata[6:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  // Changing either output role restarts the clock divider.
  assign phase_clear = cfg_wr_en &&
                       (cfg_index == REG_FUNCTION_A || cfg_index == REG_FUNCTION_B);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.listen_channel   <= 4'd0;
      cfg_r.function_a       <= ROLE_NOTE;
      cfg_r.function_b       <= ROLE_GATE;
      cfg_r.full_scale_level <= 15'd7680;
      cfg_r.bend_scale_level <= 15'd4608;
      cfg_r.semitone_step    <= 10'd128;
      cfg_r.zero_note        <= 7'd60;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/mecr_scaler.sv
// Level arithmetic: note CV, 7-bit proportions and pitch bend proportion.
module mecr_scaler
  import mecr_pkg::*;
(
  input  in_item_t in_data,
  input  cfg_t     cfg,
  output levels_t  levels
);

  // Floor division by 127 through remainder folding: x = 127*q + r.
  function automatic logic [14:0] div127(logic [21:0] x);
    logic [14:0] q1;
    logic [15:0] r1;
    logic [8:0]  q2;
    logic [8:0]  r2;
    logic [1:0]  q3;
    logic [7:0]  r3;
    logic [15:0] q;
    q1 = x[21:7];
    r1 = {9'd0, x[6:0]} + {1'b0, q1};
    q2 = r1[15:7];
    r2 = {2'd0, r1[6:0]} + q2;
    q3 = r2[8:7];
    r3 = {1'b0, r2[6:0]} + {6'd0, q3};
    q  = {1'b0, q1} + {7'd0, q2} + {14'd0, q3} + {15'd0, (r3 >= 8'd127)};
    return q[14:0];
  endfunction

  // Floor division by 32767 with the same folding.
  function automatic logic [13:0] div32767(logic [28:0] x);
    logic [13:0] q1;
    logic [15:0] r1;
    logic        q2;
    logic [15:0] r2;
    logic        corr;
    logic [14:0] q;
    q1   = x[28:15];
    r1   = {1'b0, x[14:0]} + {2'd0, q1};
    q2   = r1[15];
    r2   = {1'b0, r1[14:0]} + {15'd0, q2};
    corr = (r2 >= 16'd32767);
    q    = {1'b0, q1} + {14'd0, q2} + {14'd0, corr};
    return q[13:0];
  endfunction

  logic signed [7:0]  note_diff;
  logic signed [18:0] note_prod;
  logic [6:0]         prop_val;
  logic [21:0]        prop_prod;
  logic [14:0]        prop_quo;
  logic [13:0]        bend_raw;
  logic               bend_neg;
  logic [13:0]        bend_mag;
  logic [28:0]        bend_prod;
  logic [13:0]        bend_quo;

  always_comb begin
    note_diff = $signed({1'b0, in_data.first_data}) - $signed({1'b0, cfg.zero_note});
    note_prod = 19'(note_diff) * $signed({9'd0, cfg.semitone_step});
    if (note_prod > 19'sd32767) begin
      levels.note = 16'sh7fff;
    end else if (note_prod < -19'sd32768) begin
      levels.note = -16'sd32768;
    end else begin
      levels.note = note_prod[15:0];
    end
  end

  // Aftertouch scales its first data byte; velocity and mod wheel the second.
  always_comb begin
    prop_val    = (in_data.event_kind == KIND_PRESSURE) ? in_data.first_data
                                                        : in_data.second_data;
    prop_prod   = {15'd0, prop_val} * {7'd0, cfg.full_scale_level};
    prop_quo    = div127(prop_prod);
    levels.prop = $signed({1'b0, prop_quo});
  end

  // The bend is split into sign and magnitude so the quotient truncates toward zero.
  always_comb begin
    bend_raw  = {in_data.second_data, in_data.first_data};
    bend_neg  = (bend_raw < BEND_CENTER);
    bend_mag  = bend_neg ? (BEND_CENTER - bend_raw) : (bend_raw - BEND_CENTER);
    bend_prod = {15'd0, bend_mag} * {14'd0, cfg.bend_scale_level};
    bend_quo  = div32767(bend_prod);
    if (bend_neg) begin
      levels.bend = -$signed({2'b00, bend_quo});
    end else begin
      levels.bend = $signed({2'b00, bend_quo});
    end
  end

endmodule

>>> rtl/mecr_router.sv
// Event decode, per-output action selection, clock divider and held note tracking.
module mecr_router
  import mecr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_accept,
  input  in_item_t  in_data,
  input  cfg_t      cfg,
  input  logic      phase_clear,
  input  levels_t   levels,
  output out_item_t item
);

  function automatic act_t lane_act(logic [3:0] role, kind_t kind, logic chan_ok,
                                    logic clk_hit, logic off_hit, logic cc_mod);
    act_t act;
    act = ACT_NONE;
    case (kind)
      KIND_CLOCK: begin
        if (clk_hit && role == ROLE_CLOCK) act = ACT_PULSE;
      end
      KIND_START: begin
        if (role == ROLE_START) act = ACT_PULSE;
      end
      KIND_NOTE_ON: begin
        if (chan_ok) begin
          case (role)
            ROLE_NOTE: act = ACT_LEVEL;
            ROLE_TRIG: act = ACT_PULSE;
            ROLE_GATE: act = ACT_GATE_ON;
            ROLE_VEL:  act = ACT_LEVEL;
            default:   act = ACT_NONE;
          endcase
        end
      end
      KIND_NOTE_OFF: begin
        if (off_hit && role == ROLE_GATE) act = ACT_GATE_OFF;
      end
      KIND_CONTROL: begin
        if (chan_ok && cc_mod && role == ROLE_MOD) act = ACT_LEVEL;
      end
      KIND_PRESSURE: begin
        if (chan_ok && role == ROLE_AFT) act = ACT_LEVEL;
      end
      KIND_BEND: begin
        if (chan_ok && role == ROLE_BEND) act = ACT_LEVEL;
      end
      default: act = ACT_NONE;
    endcase
    return act;
  endfunction

  function automatic logic signed [15:0] lane_level(logic [3:0] role, act_t act,
                                                    levels_t lv);
    logic signed [15:0] level;
    level = 16'sd0;
    if (act == ACT_LEVEL) begin
      case (role)
        ROLE_NOTE:                     level = lv.note;
        ROLE_VEL, ROLE_MOD, ROLE_AFT:  level = lv.prop;
        ROLE_BEND:                     level = lv.bend;
        default:                       level = 16'sd0;
      endcase
    end
    return level;
  endfunction

  logic [3:0] phase_r;
  logic [3:0] phase_nxt;
  logic       held_valid_r;
  logic       held_valid_nxt;
  logic [6:0] held_note_r;
  logic [6:0] held_note_nxt;

  kind_t      kind;
  logic       chan_ok;
  logic [3:0] phase_inc;
  logic       clk_hit;
  logic       off_hit;
  logic       cc_mod;
  act_t       act_a;
  act_t       act_b;

  always_comb begin
    kind      = kind_t'(in_data.event_kind);
    chan_ok   = (in_data.event_channel == cfg.listen_channel);
    phase_inc = phase_r + 4'd1;
    clk_hit   = (phase_inc == 4'd1);
    off_hit   = chan_ok && held_valid_r && (in_data.first_data == held_note_r);
    cc_mod    = (in_data.first_data == MOD_WHEEL_CC);
    act_a     = lane_act(cfg.function_a, kind, chan_ok, clk_hit, off_hit, cc_mod);
    act_b     = lane_act(cfg.function_b, kind, chan_ok, clk_hit, off_hit, cc_mod);
  end

  always_comb begin
    item.a_action = act_a;
    item.a_level  = lane_level(cfg.function_a, act_a, levels);
    item.b_action = act_b;
    item.b_level  = lane_level(cfg.function_b, act_b, levels);
    // Clock ticks are never logged even when they pulse an output.
    item.logged   = (kind == KIND_START) ||
                    (kind == KIND_NOTE_ON && chan_ok) ||
                    (kind != KIND_CLOCK && (act_a != ACT_NONE || act_b != ACT_NONE));
  end

  always_comb begin
    phase_nxt      = phase_r;
    held_valid_nxt = held_valid_r;
    held_note_nxt  = held_note_r;
    if (phase_clear) begin
      phase_nxt = 4'd0;
    end else if (in_accept) begin
      case (kind)
        KIND_CLOCK: begin
          phase_nxt = (phase_inc >= CLOCK_DIVIDE) ? 4'd0 : phase_inc;
        end
        KIND_NOTE_ON: begin
          if (chan_ok) begin
            held_valid_nxt = 1'b1;
            held_note_nxt  = in_data.first_data;
          end
        end
        KIND_NOTE_OFF: begin
          if (off_hit) held_valid_nxt = 1'b0;
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= 4'd0;
      held_valid_r <= 1'b0;
      held_note_r  <= 7'd0;
    end else begin
      phase_r      <= phase_nxt;
      held_valid_r <= held_valid_nxt;
      held_note_r  <= held_note_nxt;
    end
  end

endmodule

>>> rtl/midi_event_to_cv_router_unit.sv
// Top level of the MIDI event to CV router: handshake, result register and assertions.
// The router takes one decoded MIDI event per transaction and returns one result per
// event with an action and level for each of the two outputs plus a logged flag. It
// accepts a transaction whenever in_ready is high; the result shows up in the output
// register in the cycle after acceptance, and in_ready follows out_ready combinationally
// while that register is full, so throughput is one event per clock while out_ready
// stays high. Configuration writes take effect on the next edge and must be made
// while no result is pending; writing either function register restarts the clock
// divider.
module midi_event_to_cv_router_unit
  import mecr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_data,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cfg_t      cfg;
  logic      phase_clear;
  levels_t   levels;
  out_item_t item_nxt;
  logic      in_accept;

  out_item_t out_data_r;
  logic      out_valid_r;
  logic      out_valid_nxt;

  mecr_cfg_regs u_cfg_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .cfg         (cfg),
    .phase_clear (phase_clear)
  );

  mecr_scaler u_scaler (
    .in_data (in_data),
    .cfg     (cfg),
    .levels  (levels)
  );

  mecr_router u_router (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_accept   (in_accept),
    .in_data     (in_data),
    .cfg         (cfg),
    .phase_clear (phase_clear),
    .levels      (levels),
    .item        (item_nxt)
  );

  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  // Every accepted transaction must produce a result on the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_valid_r)
    else $error("accepted transaction produced no result");

  // A level is only meaningful with a set-level action.
  a_level_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_data_r.a_action == ACT_LEVEL || out_data_r.a_level == 16'sd0) &&
                     (out_data_r.b_action == ACT_LEVEL || out_data_r.b_level == 16'sd0)))
    else $error("nonzero level without a set-level action");

  // Clock ticks never enter the log.
  a_clock_not_logged: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_data.event_kind == KIND_CLOCK) |=> !out_data_r.logged)
    else $error("clock tick was logged");
`endif

endmodule

>>> tb/sv/midi_event_to_cv_router_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the MIDI event to CV router: directed and random events.
module midi_event_to_cv_router_unit_tb;
  import mecr_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;

  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 3'd7;
  localparam logic [3:0] ROLE_UNUSED_LOW  = 4'd9;
  localparam logic [3:0] ROLE_UNUSED_HIGH = 4'd15;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  in_item_t               in_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_item_t              out_data;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  // Predictor copy of the registers and of the router state.
  logic [3:0]  pr_listen;
  logic [3:0]  pr_fn_a;
  logic [3:0]  pr_fn_b;
  logic [14:0] pr_full;
  logic [14:0] pr_bend;
  logic [9:0]  pr_step;
  logic [6:0]  pr_zero;
  logic [3:0]  tick_count;
  logic        note_held;
  logic [6:0]  held_key;

  out_item_t expected_results[$];
  int        mismatch_count = 0;
  int        cycle_count = 0;

  // Stimulus and flow control.
  logic [3:0] chan_on = 4'd0;
  logic [6:0] last_key = 7'd0;
  bit         bursty = 1'b1;
  int         burst_left = 0;
  bit         hold_request = 1'b0;
  int         hold_left = 0;
  int         sink_mode = 0;
  int         mode_left = 0;
  int         pattern_count = 0;

  midi_event_to_cv_router_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [15:0] clamp16(int v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] scaled(int value, int divisor, logic [14:0] scale);
    return clamp16(value * int'(scale) / divisor);
  endfunction

  // Works out the result of one accepted event and advances the predictor state.
  function automatic out_item_t route_event(in_item_t ev);
    out_item_t          res;
    logic [3:0]         role [2];
    act_t               act [2];
    logic signed [15:0] lvl [2];
    logic               lg;
    int                 bend_val;
    int                 k;
    role[0] = pr_fn_a;
    role[1] = pr_fn_b;
    act[0] = ACT_NONE;
    act[1] = ACT_NONE;
    lvl[0] = '0;
    lvl[1] = '0;
    lg = 1'b0;
    bend_val = int'({ev.second_data, ev.first_data}) - int'(BEND_CENTER);
    if (ev.event_kind == KIND_CLOCK) begin
      tick_count = tick_count + 4'd1;
      if (tick_count == 4'd1) begin
        for (k = 0; k < 2; k++)
          if (role[k] == ROLE_CLOCK) act[k] = ACT_PULSE;
      end
      if (tick_count >= CLOCK_DIVIDE) tick_count = '0;
    end else if (ev.event_kind == KIND_START) begin
      for (k = 0; k < 2; k++)
        if (role[k] == ROLE_START) act[k] = ACT_PULSE;
      lg = 1'b1;
    end else if (ev.event_channel == pr_listen) begin
      case (kind_t'(ev.event_kind))
        KIND_NOTE_ON: begin
          held_key = ev.first_data;
          note_held = 1'b1;
          lg = 1'b1;
          for (k = 0; k < 2; k++) begin
            case (role[k])
              ROLE_NOTE: begin
                act[k] = ACT_LEVEL;
                lvl[k] = clamp16((int'(ev.first_data) - int'(pr_zero)) * int'(pr_step));
              end
              ROLE_TRIG: act[k] = ACT_PULSE;
              ROLE_GATE: act[k] = ACT_GATE_ON;
              ROLE_VEL: begin
                act[k] = ACT_LEVEL;
                lvl[k] = scaled(int'(ev.second_data), 127, pr_full);
              end
              default: ;
            endcase
          end
        end
        KIND_NOTE_OFF: begin
          // Only the most recent note closes the gate.
          if (note_held && ev.first_data == held_key) begin
            note_held = 1'b0;
            for (k = 0; k < 2; k++) begin
              if (role[k] == ROLE_GATE) begin
                act[k] = ACT_GATE_OFF;
                lg = 1'b1;
              end
            end
          end
        end
        KIND_CONTROL: begin
          for (k = 0; k < 2; k++) begin
            if (role[k] == ROLE_MOD && ev.first_data == MOD_WHEEL_CC) begin
              act[k] = ACT_LEVEL;
              lvl[k] = scaled(int'(ev.second_data), 127, pr_full);
              lg = 1'b1;
            end
          end
        end
        KIND_PRESSURE: begin
          for (k = 0; k < 2; k++) begin
            if (role[k] == ROLE_AFT) begin
              act[k] = ACT_LEVEL;
              lvl[k] = scaled(int'(ev.first_data), 127, pr_full);
              lg = 1'b1;
            end
          end
        end
        KIND_BEND: begin
          for (k = 0; k < 2; k++) begin
            if (role[k] == ROLE_BEND) begin
              act[k] = ACT_LEVEL;
              lvl[k] = scaled(bend_val, 32'h7fff, pr_bend);
              lg = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
    res.a_action = act[0];
    res.a_level  = lvl[0];
    res.b_action = act[1];
    res.b_level  = lvl[1];
    res.logged   = lg;
    return res;
  endfunction

  task automatic check_field(string name, logic signed [15:0] want, logic signed [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Tracks register writes and accepted events, and checks every accepted result.
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (!rst_n) begin
      pr_listen  = 4'd0;
      pr_fn_a    = ROLE_NOTE;
      pr_fn_b    = ROLE_GATE;
      pr_full    = 15'd7680;
      pr_bend    = 15'd4608;
      pr_step    = 10'd128;
      pr_zero    = 7'd60;
      tick_count = '0;
      note_held  = 1'b0;
      held_key   = '0;
      expected_results.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_LISTEN_CHANNEL: pr_listen = cfg_wdata[3:0];
          REG_FUNCTION_A: begin
            pr_fn_a = cfg_wdata[3:0];
            tick_count = '0;
          end
          REG_FUNCTION_B: begin
            pr_fn_b = cfg_wdata[3:0];
            tick_count = '0;
          end
          REG_FULL_SCALE:    pr_full = cfg_wdata[14:0];
          REG_BEND_SCALE:    pr_bend = cfg_wdata[14:0];
          REG_SEMITONE_STEP: pr_step = cfg_wdata[9:0];
          REG_ZERO_NOTE:     pr_zero = cfg_wdata[6:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) expected_results.push_back(route_event(in_data));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with no event pending, expected none, actual %p",
                   $time, out_data);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("a_action", 16'(want.a_action), 16'(out_data.a_action));
          check_field("a_level", want.a_level, out_data.a_level);
          check_field("b_action", 16'(want.b_action), 16'(out_data.b_action));
          check_field("b_level", want.b_level, out_data.b_level);
          check_field("logged", 16'(want.logged), 16'(out_data.logged));
        end
      end
    end
  end

  // Receiver: switches between always ready, random stalls and a fixed pattern,
  // and holds off completely for a long stretch on request.
  always @(posedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (mode_left == 0) begin
      sink_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(16, 96);
    end else begin
      mode_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (sink_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        default: begin
          out_ready <= (pattern_count != 0);
          pattern_count = (pattern_count + 1) % 3;
        end
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Offers one event, waits for its transaction, then maybe pauses between bursts.
  task automatic send_event(in_item_t ev);
    in_valid <= 1'b1;
    in_data <= ev;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (bursty) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  function automatic in_item_t make_event(kind_t kind, logic [3:0] ch, logic [6:0] d1,
                                          logic [6:0] d2);
    in_item_t ev;
    ev.event_kind    = kind;
    ev.event_channel = ch;
    ev.first_data    = d1;
    ev.second_data   = d2;
    return ev;
  endfunction

  function automatic logic [6:0] rand_data();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 7'd0;
    if (pick == 1) return 7'd127;
    return 7'($urandom);
  endfunction

  // Mostly well-formed traffic on the listened channel: note on and matching note off,
  // streams of clock ticks and controller 1, with some noise on other channels.
  function automatic in_item_t random_event(logic [3:0] chan);
    in_item_t ev;
    int       pick;
    ev = make_event(KIND_OTHER, chan, rand_data(), rand_data());
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      ev.event_kind = KIND_CLOCK;
      ev.event_channel = 4'($urandom);
    end else if (pick < 30) begin
      ev.event_kind = KIND_START;
      ev.event_channel = 4'($urandom);
    end else if (pick < 50) begin
      ev.event_kind = KIND_NOTE_ON;
      last_key = ev.first_data;
    end else if (pick < 65) begin
      ev.event_kind = KIND_NOTE_OFF;
      if ($urandom_range(0, 9) < 7) ev.first_data = last_key;
    end else if (pick < 75) begin
      ev.event_kind = KIND_CONTROL;
      if ($urandom_range(0, 1) == 1) ev.first_data = MOD_WHEEL_CC;
    end else if (pick < 83) begin
      ev.event_kind = KIND_PRESSURE;
    end else if (pick < 91) begin
      ev.event_kind = KIND_BEND;
    end else if (pick < 95) begin
      ev.event_channel = 4'($urandom);
    end else begin
      ev.event_kind = 3'($urandom_range(KIND_NOTE_ON, KIND_BEND));
      ev.event_channel = chan ^ 4'($urandom_range(1, 15));
    end
    return ev;
  endfunction

  task automatic set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  // Waits until the router is idle, then writes every register. Unused upper data bits
  // carry random garbage, and the unmapped index gets a write that must be ignored.
  task automatic configure(logic [3:0] listen, logic [3:0] fn_a, logic [3:0] fn_b,
                           logic [14:0] full, logic [14:0] bend, logic [9:0] step,
                           logic [6:0] zero);
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    set_reg(REG_LISTEN_CHANNEL, {11'($urandom), listen});
    set_reg(REG_FUNCTION_A, {11'($urandom), fn_a});
    set_reg(REG_FUNCTION_B, {11'($urandom), fn_b});
    set_reg(REG_FULL_SCALE, full);
    set_reg(REG_BEND_SCALE, bend);
    set_reg(REG_SEMITONE_STEP, {5'($urandom), step});
    set_reg(REG_ZERO_NOTE, {8'($urandom), zero});
    set_reg(REG_UNMAPPED, 15'($urandom));
    cfg_wr_en <= 1'b0;
    chan_on = listen;
  endtask

  task automatic run_events(int count);
    repeat (count) send_event(random_event(chan_on));
  endtask

  // Reset settings: A follows the note, B is the gate, channel 0.
  task automatic test_directed_events();
    send_event(make_event(KIND_NOTE_ON, 4'd0, 7'd0, 7'd0));
    send_event(make_event(KIND_NOTE_ON, 4'd0, 7'd127, 7'd127));
    send_event(make_event(KIND_NOTE_OFF, 4'd0, 7'd127, 7'd0));
    send_event(make_event(KIND_NOTE_OFF, 4'd0, 7'd127, 7'd0));
    send_event(make_event(KIND_NOTE_ON, 4'd0, 7'd60, 7'd64));
    send_event(make_event(KIND_NOTE_OFF, 4'd0, 7'd61, 7'd0));
    send_event(make_event(KIND_NOTE_ON, 4'd15, 7'd72, 7'd100));
    send_event(make_event(KIND_NOTE_OFF, 4'd0, 7'd60, 7'd127));
    send_event(make_event(KIND_CLOCK, 4'd15, 7'd127, 7'd127));
    send_event(make_event(KIND_CLOCK, 4'd0, 7'd0, 7'd0));
    send_event(make_event(KIND_START, 4'd9, 7'd0, 7'd0));
    send_event(make_event(KIND_OTHER, 4'd0, 7'd127, 7'd127));
    send_event(make_event(KIND_OTHER, 4'd15, 7'd0, 7'd0));
    send_event(make_event(KIND_CONTROL, 4'd0, MOD_WHEEL_CC, 7'd127));
    send_event(make_event(KIND_CONTROL, 4'd0, 7'd0, 7'd0));
    send_event(make_event(KIND_CONTROL, 4'd0, 7'd127, 7'd64));
    send_event(make_event(KIND_PRESSURE, 4'd0, 7'd127, 7'd0));
    send_event(make_event(KIND_BEND, 4'd0, 7'd0, 7'd0));
    send_event(make_event(KIND_BEND, 4'd0, 7'd127, 7'd127));
    send_event(make_event(KIND_BEND, 4'd8, 7'd0, 7'd64));
    // A newer note takes over; the older note's release must be ignored.
    send_event(make_event(KIND_NOTE_ON, 4'd0, 7'd127, 7'd1));
    send_event(make_event(KIND_NOTE_ON, 4'd0, 7'd5, 7'd0));
    send_event(make_event(KIND_NOTE_OFF, 4'd0, 7'd127, 7'd0));
    send_event(make_event(KIND_NOTE_OFF, 4'd0, 7'd5, 7'd0));
  endtask

  task automatic test_role_pairs();
    configure(4'd15, ROLE_TRIG, ROLE_VEL, 15'd32767, 15'd32767, 10'd1023, 7'd0);
    run_events(45);
    configure(4'd5, ROLE_MOD, ROLE_AFT, 15'd0, 15'd0, 10'd0, 7'd127);
    run_events(45);
    configure(4'd9, ROLE_BEND, ROLE_CLOCK, 15'd1, 15'd32767, 10'd1, 7'd64);
    run_events(50);
    configure(4'd3, ROLE_START, ROLE_UNUSED_LOW, 15'd32767, 15'd1, 10'd512, 7'd1);
    run_events(40);
    // Both outputs on the divided clock; the function writes restart the count.
    configure(4'd12, ROLE_CLOCK, ROLE_CLOCK, 15'd100, 15'd200, 10'd3, 7'd10);
    bursty = 1'b0;
    run_events(50);
    bursty = 1'b1;
    configure(4'd0, ROLE_NOTE, ROLE_NOTE, 15'd7680, 15'd4608, 10'd1023, 7'd0);
    run_events(40);
    configure(4'd6, ROLE_NOTE, ROLE_VEL, 15'd32767, 15'd4608, 10'd1023, 7'd127);
    run_events(40);
    configure(4'd7, ROLE_UNUSED_HIGH, ROLE_GATE, 15'd7680, 15'd4608, 10'd128, 7'd60);
    run_events(40);
    configure(4'd1, ROLE_GATE, ROLE_BEND, 15'd7680, 15'd0, 10'd128, 7'd60);
    run_events(40);
  endtask

  // The sender keeps offering while the receiver holds off, so the router stalls.
  task automatic test_backpressure();
    configure(4'd2, ROLE_VEL, ROLE_TRIG, 15'd12345, 15'd32767, 10'd64, 7'd30);
    bursty = 1'b0;
    hold_request = 1'b1;
    run_events(40);
    bursty = 1'b1;
  endtask

  task automatic test_random_settings();
    repeat (4) begin
      configure(4'($urandom), 4'($urandom_range(0, 10)), 4'($urandom_range(0, 10)),
                15'($urandom), 15'($urandom), 10'($urandom), 7'($urandom));
      run_events(40);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_events();
    test_role_pairs();
    test_backpressure();
    test_random_settings();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
